// ===== hw/rtl/tgsp_pkg.sv =====
// Shared types and constants of the typed graph shortest path unit.
package tgsp_pkg;

    // Field widths of the request and result items.
    localparam int REQ_W      = 2;
    localparam int NODE_IDX_W = 11;
    localparam int KIND_W     = 7;
    localparam int DIST_W     = 21;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_COUNT = 1'd1;
    localparam int NODE_COUNT_W = 11;
    localparam int KIND_COUNT_W = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD_KIND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_PERM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN       = 2'd2;

    // Default sizes.
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_KINDS = 64;

    // One entry of the distance memory.
    typedef struct packed {
        logic              settled;
        logic              inf;
        logic [DIST_W-1:0] cost;
    } t_dist_ent;

    // Write request towards the permission store.
    typedef struct packed {
        logic              en;
        logic [KIND_W-1:0] row;
        logic [KIND_W-1:0] col;
        logic              allow;
    } t_perm_wr;

endpackage

// ===== hw/rtl/tgsp_perm_store.sv =====
// Permission matrix held as one memory row per source kind, with row valid bits.
module tgsp_perm_store
    import tgsp_pkg::*;
#(
    parameter int MAX_KINDS = DEF_MAX_KINDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_perm_wr             i_wr,
    input  logic [KIND_W-1:0]    i_rd_row,
    output logic [MAX_KINDS-1:0] o_row,
    output logic                 o_busy
);

    localparam int KA = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;

    logic [MAX_KINDS-1:0] row_mem [MAX_KINDS];
    logic [MAX_KINDS-1:0] r_row_vld;
    logic [MAX_KINDS-1:0] r_q;
    logic                 r_q_ok;
    logic                 r_pend;
    logic [KA-1:0]        r_pend_row;
    logic [KA-1:0]        r_pend_col;
    logic                 r_pend_allow;
    logic [KA-1:0]        rd_addr;
    logic [MAX_KINDS-1:0] new_row;

    // A write reads the row first; otherwise the search side picks the row.
    always_comb begin
        if (i_wr.en) begin
            rd_addr = KA'(i_wr.row - 1'b1);
        end else begin
            rd_addr = KA'(i_rd_row - 1'b1);
        end
    end

    assign o_row  = r_q_ok ? r_q : '0;
    assign o_busy = r_pend;

    // Merge the single new bit into the row read last cycle.
    always_comb begin
        new_row             = o_row;
        new_row[r_pend_col] = r_pend_allow;
    end

    // Registered read and write-back of the row memory.
    always_ff @(posedge i_clk) begin
        r_q    <= row_mem[rd_addr];
        r_q_ok <= r_row_vld[rd_addr];
        if (r_pend) begin
            row_mem[r_pend_row] <= new_row;
        end
        r_pend_row   <= KA'(i_wr.row - 1'b1);
        r_pend_col   <= KA'(i_wr.col - 1'b1);
        r_pend_allow <= i_wr.allow;
    end

    // Control state: pending write and row valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_pend <= i_wr.en;
            if (r_pend) begin
                r_row_vld[r_pend_row] <= 1'b1;
            end
        end
    end

    // A new write never arrives while one is still being merged.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_wr.en)
        else $error("permission write overlaps a pending write");

    // A merged row is valid from the next cycle on.
    a_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_row_vld[$past(r_pend_row)])
        else $error("row not marked valid after write");

    // Busy follows every permission write.
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> o_busy)
        else $error("busy missing after permission write");

endmodule

// ===== hw/rtl/typed_graph_shortest_path_unit.sv =====
// Top level of the typed graph shortest path unit: memories and search sequencer.
// A kind load writes the kind memory directly; a matrix load reads the row and then
// writes it back, and requests are refused meanwhile. A run first sweeps the distance
// memory over the n nodes in use, then repeats a dense label-setting step: a scan over
// all n distances picks the nearest unsettled node, the PICK, KP and ROW states settle
// it and fetch its kind and permission row, and a relax pass over all n nodes updates
// their distances (the relax pass is skipped when the node's kind is zero or above the
// kind count). The step repeats once per reachable node, until a last scan finds none.
// The single read and write port of the distance memory makes each scan and relax pass
// walk the nodes one at a time. The result item waits in an output register; loads and
// a new run are still taken while it is held, and a run that ends before the held item
// leaves waits in its last step.
module typed_graph_shortest_path_unit
    import tgsp_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_KINDS = DEF_MAX_KINDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [NODE_IDX_W-1:0] i_node_index,
    input  logic [KIND_W-1:0]     i_node_kind,
    input  logic [KIND_W-1:0]     i_from_kind,
    input  logic [KIND_W-1:0]     i_to_kind,
    input  logic                  i_allowed,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DIST_W-1:0]     o_distance,
    output logic                  o_unreachable
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 2);
    localparam int KW = $clog2(MAX_KINDS + 2);
    localparam int KA = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_KP    = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_RELAX = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FIN2  = 4'd8;

    // Configuration registers.
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [KIND_COUNT_W-1:0] r_kind_count;

    // Memories.
    t_dist_ent         dist_mem [MAX_NODES];
    logic [KIND_W-1:0] kind_mem [MAX_NODES];
    t_dist_ent         r_dq;
    logic [KIND_W-1:0] r_kq;

    // Sequencer state.
    logic [3:0]           r_state,    n_state;
    logic [NW-1:0]        r_nact,     n_nact;
    logic [KW-1:0]        r_kact,     n_kact;
    logic [NW-1:0]        r_ctr,      n_ctr;
    logic                 r_rv,       n_rv;
    logic [NW-1:0]        r_ridx,     n_ridx;
    logic                 r_best_vld, n_best_vld;
    logic [DIST_W-1:0]    r_best_d,   n_best_d;
    logic [NW-1:0]        r_best_p,   n_best_p;
    logic [NW-1:0]        r_p,        n_p;
    logic [DIST_W-1:0]    r_bd,       n_bd;
    logic [MAX_KINDS-1:0] r_prow,     n_prow;
    logic                 r_out_vld,  n_out_vld;
    logic [DIST_W-1:0]    r_out_d,    n_out_d;
    logic                 r_out_unr,  n_out_unr;

    // Memory access controls.
    logic          dist_we;
    logic [AW-1:0] dist_waddr;
    t_dist_ent     dist_wdata;
    logic [AW-1:0] dist_raddr;
    logic [AW-1:0] kind_raddr;
    logic          kind_we;

    // Permission store link.
    t_perm_wr             perm_wr;
    logic [KIND_W-1:0]    perm_rd_row;
    logic [MAX_KINDS-1:0] perm_row;
    logic                 perm_busy;

    // Helpers.
    logic              in_acc;
    logic              kind_idx_ok;
    logic              perm_idx_ok;
    logic [NW-1:0]     node_gap;
    logic [DIST_W-1:0] cand;
    logic [KIND_W-1:0] ky_m1;
    logic              ky_ok;
    logic              kp_ok;

    assign o_in_ready    = (r_state == S_IDLE) && !perm_busy;
    assign in_acc        = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_vld;
    assign o_distance    = r_out_d;
    assign o_unreachable = r_out_unr;

    assign kind_idx_ok = (i_node_index != '0) && (32'(i_node_index) <= 32'(MAX_NODES));
    assign perm_idx_ok = (i_from_kind != '0) && (32'(i_from_kind) <= 32'(MAX_KINDS))
                      && (i_to_kind != '0) && (32'(i_to_kind) <= 32'(MAX_KINDS));
    assign kind_we     = in_acc && (i_req_type == REQ_LOAD_KIND) && kind_idx_ok;

    assign perm_wr.en    = in_acc && (i_req_type == REQ_LOAD_PERM) && perm_idx_ok;
    assign perm_wr.row   = i_from_kind;
    assign perm_wr.col   = i_to_kind;
    assign perm_wr.allow = i_allowed;
    assign perm_rd_row   = r_kq;

    // Candidate distance of the node returned by the memories this cycle.
    assign node_gap = (r_p > r_ridx) ? (r_p - r_ridx) : (r_ridx - r_p);
    assign cand     = r_bd + DIST_W'(node_gap);
    assign ky_m1    = r_kq - 1'b1;
    assign ky_ok    = (r_kq != '0) && ({1'b0, r_kq} <= (KIND_W + 1)'(r_kact));
    assign kp_ok    = ky_ok;

    // Read addresses follow the state.
    always_comb begin
        if ((r_state == S_FIN) || (r_state == S_FIN2)) begin
            dist_raddr = AW'(r_nact - 1'b1);
        end else begin
            dist_raddr = AW'(r_ctr - 1'b1);
        end
        if (r_state == S_PICK) begin
            kind_raddr = AW'(r_best_p - 1'b1);
        end else begin
            kind_raddr = AW'(r_ctr - 1'b1);
        end
    end

    // Search sequencer.
    always_comb begin
        n_state    = r_state;
        n_nact     = r_nact;
        n_kact     = r_kact;
        n_ctr      = r_ctr;
        n_rv       = 1'b0;
        n_ridx     = r_ctr;
        n_best_vld = r_best_vld;
        n_best_d   = r_best_d;
        n_best_p   = r_best_p;
        n_p        = r_p;
        n_bd       = r_bd;
        n_prow     = r_prow;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_d    = r_out_d;
        n_out_unr  = r_out_unr;
        dist_we    = 1'b0;
        dist_waddr = AW'(r_ctr - 1'b1);
        dist_wdata = '{settled: 1'b0, inf: 1'b1, cost: '0};
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_RUN)) begin
                    if (r_node_count == '0) begin
                        n_nact = NW'(1);
                    end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
                        n_nact = NW'(MAX_NODES);
                    end else begin
                        n_nact = NW'(r_node_count);
                    end
                    if (32'(r_kind_count) > 32'(MAX_KINDS)) begin
                        n_kact = KW'(MAX_KINDS);
                    end else begin
                        n_kact = KW'(r_kind_count);
                    end
                    n_ctr   = NW'(1);
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                // Node 1 starts at zero, all others at infinity.
                dist_we         = 1'b1;
                dist_wdata.inf  = (r_ctr != NW'(1));
                n_ctr           = r_ctr + 1'b1;
                if (r_ctr == r_nact) begin
                    n_ctr      = NW'(1);
                    n_best_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ctr <= r_nact) begin
                    n_rv  = 1'b1;
                    n_ctr = r_ctr + 1'b1;
                end
                if (r_rv && !r_dq.settled && !r_dq.inf
                        && (!r_best_vld || (r_dq.cost < r_best_d))) begin
                    n_best_vld = 1'b1;
                    n_best_d   = r_dq.cost;
                    n_best_p   = r_ridx;
                end
                if ((r_ctr > r_nact) && !r_rv) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_best_vld) begin
                    n_state = S_FIN;
                end else begin
                    // Settle the nearest node and fetch its kind.
                    dist_we    = 1'b1;
                    dist_waddr = AW'(r_best_p - 1'b1);
                    dist_wdata = '{settled: 1'b1, inf: 1'b0, cost: r_best_d};
                    n_p        = r_best_p;
                    n_bd       = r_best_d;
                    n_state    = S_KP;
                end
            end
            S_KP: begin
                n_ctr      = NW'(1);
                n_best_vld = 1'b0;
                if (kp_ok) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ROW: begin
                n_prow  = perm_row;
                n_ctr   = NW'(1);
                n_state = S_RELAX;
            end
            S_RELAX: begin
                if (r_ctr <= r_nact) begin
                    n_rv  = 1'b1;
                    n_ctr = r_ctr + 1'b1;
                end
                if (r_rv && (r_ridx != r_p) && !r_dq.settled && ky_ok
                        && r_prow[KA'(ky_m1)] && (r_dq.inf || (cand < r_dq.cost))) begin
                    dist_we    = 1'b1;
                    dist_waddr = AW'(r_ridx - 1'b1);
                    dist_wdata = '{settled: 1'b0, inf: 1'b0, cost: cand};
                end
                if ((r_ctr > r_nact) && !r_rv) begin
                    n_ctr      = NW'(1);
                    n_best_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_FIN: begin
                n_state = S_FIN2;
            end
            S_FIN2: begin
                // Hand the result over once the output register is free.
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out_unr = r_dq.inf;
                    n_out_d   = r_dq.inf ? '0 : r_dq.cost;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Distance and kind memories.
    always_ff @(posedge i_clk) begin
        r_dq <= dist_mem[dist_raddr];
        r_kq <= kind_mem[kind_raddr];
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (kind_we) begin
            kind_mem[AW'(i_node_index - 1'b1)] <= i_node_kind;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rv         <= 1'b0;
            r_best_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
            r_node_count <= NODE_COUNT_W'(1);
            r_kind_count <= KIND_COUNT_W'(1);
        end else begin
            r_state    <= n_state;
            r_rv       <= n_rv;
            r_best_vld <= n_best_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we && (i_cfg_idx == CFG_NODE_COUNT)) begin
                r_node_count <= NODE_COUNT_W'(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == CFG_KIND_COUNT)) begin
                r_kind_count <= KIND_COUNT_W'(i_cfg_data);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_nact   <= n_nact;
        r_kact   <= n_kact;
        r_ctr    <= n_ctr;
        r_ridx   <= n_ridx;
        r_best_d <= n_best_d;
        r_best_p <= n_best_p;
        r_p      <= n_p;
        r_bd     <= n_bd;
        r_prow   <= n_prow;
        r_out_d  <= n_out_d;
        r_out_unr <= n_out_unr;
    end

    tgsp_perm_store #(
        .MAX_KINDS (MAX_KINDS)
    ) u_perm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (perm_wr),
        .i_rd_row (perm_rd_row),
        .o_row    (perm_row),
        .o_busy   (perm_busy)
    );

    // The node chosen for settling lies among the nodes in use.
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_best_vld) |-> (r_best_p != '0) && (r_best_p <= r_nact))
        else $error("picked node out of range");

    // A result appears only at the end of a run.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_FIN2))
        else $error("result raised outside the final step");

    // A relax write never touches the node being expanded.
    a_relax_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX && dist_we) |-> (r_ridx != r_p))
        else $error("relax wrote the expanded node");

    // Requests are refused while the matrix store is merging a row.
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        perm_busy |-> !o_in_ready)
        else $error("ready while permission store busy");

endmodule

// ===== tb/tgsp_checker.sv =====
// Checker of the typed graph shortest path unit: predicts each search result and compares.
`timescale 1ns / 100ps

module tgsp_checker
    import tgsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [NODE_IDX_W-1:0] i_node_index,
    input  logic [KIND_W-1:0]     i_node_kind,
    input  logic [KIND_W-1:0]     i_from_kind,
    input  logic [KIND_W-1:0]     i_to_kind,
    input  logic                  i_allowed,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic                  i_unreachable,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int NODES = DEF_MAX_NODES;
    localparam int KINDS = DEF_MAX_KINDS;
    localparam longint UNSET = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unreachable;
    } t_path_result;

    // Shadow copy of the unit's registers and stores.
    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic [KIND_COUNT_W-1:0] kind_count_reg;
    logic [KIND_W-1:0]       node_kinds [1:NODES];
    bit                      move_allowed [1:KINDS][1:KINDS];
    t_path_result            pending_paths [$];
    int                      fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_paths.size();

    // Label-setting search over the shadow stores, from node 1 to the last node in use.
    function automatic t_path_result shortest_path();
        longint       best [1:NODES];
        bit           settled [1:NODES];
        int           n;
        int           kc;
        int           p;
        int           kp;
        int           ky;
        longint       bd;
        longint       cand;
        t_path_result res;
        n  = (node_count_reg == 0) ? 1 : (node_count_reg > NODES) ? NODES : node_count_reg;
        kc = (kind_count_reg > KINDS) ? KINDS : kind_count_reg;
        for (int i = 1; i <= NODES; i++) begin
            best[i]    = UNSET;
            settled[i] = 1'b0;
        end
        best[1] = 0;
        forever begin
            p  = 0;
            bd = UNSET;
            for (int i = 1; i <= n; i++) begin
                if (!settled[i] && best[i] < bd) begin
                    bd = best[i];
                    p  = i;
                end
            end
            if (p == 0) break;
            settled[p] = 1'b1;
            kp = node_kinds[p];
            if (kp < 1 || kp > kc) continue;
            for (int y = 1; y <= n; y++) begin
                ky = node_kinds[y];
                if (y == p || settled[y] || ky < 1 || ky > kc) continue;
                if (!move_allowed[kp][ky]) continue;
                cand = bd + ((p > y) ? p - y : y - p);
                if (cand < best[y]) best[y] = cand;
            end
        end
        if (best[n] == UNSET) begin
            res.distance    = '0;
            res.unreachable = 1'b1;
        end else begin
            res.distance    = best[n][DIST_W-1:0];
            res.unreachable = 1'b0;
        end
        return res;
    endfunction

    // Track configuration and loads, and predict a result for each run item.
    always @(posedge i_clk) begin
        t_path_result exp_res;
        if (!i_rst_n) begin
            node_count_reg <= 1;
            kind_count_reg <= 1;
            fail_count     = 0;
            pending_paths.delete();
            for (int i = 1; i <= NODES; i++) node_kinds[i] = '0;
            for (int r = 1; r <= KINDS; r++)
                for (int c = 1; c <= KINDS; c++) move_allowed[r][c] = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_NODE_COUNT) node_count_reg <= i_cfg_data[NODE_COUNT_W-1:0];
                else if (i_cfg_idx == CFG_KIND_COUNT)
                    kind_count_reg <= i_cfg_data[KIND_COUNT_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                case (i_req_type)
                    REQ_LOAD_KIND: begin
                        if (i_node_index >= 1 && i_node_index <= NODES)
                            node_kinds[i_node_index] = i_node_kind;
                    end
                    REQ_LOAD_PERM: begin
                        if (i_from_kind >= 1 && i_from_kind <= KINDS &&
                            i_to_kind >= 1 && i_to_kind <= KINDS)
                            move_allowed[i_from_kind][i_to_kind] = i_allowed;
                    end
                    REQ_RUN: begin
                        exp_res       = shortest_path();
                        pending_paths = {pending_paths, exp_res};
                    end
                    default: ;
                endcase
            end
            // Compare each delivered result with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (pending_paths.size() == 0) begin
                    $error("unexpected result item: distance %0d unreachable %0d",
                           i_distance, i_unreachable);
                    fail_count++;
                end else begin
                    exp_res = pending_paths.pop_front();
                    if (i_distance !== exp_res.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               exp_res.distance, i_distance);
                        fail_count++;
                    end
                    if (i_unreachable !== exp_res.unreachable) begin
                        $error("unreachable: expected %0d, actual %0d",
                               exp_res.unreachable, i_unreachable);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 100ps

module testbench;
    import tgsp_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int ITEM_TARGET    = 1450;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type;
    logic [NODE_IDX_W-1:0] i_node_index;
    logic [KIND_W-1:0]     i_node_kind;
    logic [KIND_W-1:0]     i_from_kind;
    logic [KIND_W-1:0]     i_to_kind;
    logic                  i_allowed;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_unreachable;

    int  fail_count;
    int  pending_count;
    int  items_sent;
    int  idle_cycles;
    bit  quiet;

    typed_graph_shortest_path_unit dut (.*);

    tgsp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_node_index (i_node_index),
        .i_node_kind  (i_node_kind),
        .i_from_kind  (i_from_kind),
        .i_to_kind    (i_to_kind),
        .i_allowed    (i_allowed),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_distance   (o_distance),
        .i_unreachable(o_unreachable),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side stalls in random bursts, and never in the quiet part of the run.
    int ready_burst;
    initial ready_burst = 0;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (ready_burst > 0) begin
            ready_burst <= ready_burst - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            ready_burst <= $urandom_range(0, 15);
        end else begin
            i_out_ready <= 1'b1;
            ready_burst <= $urandom_range(0, 12);
        end
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** typed_graph_shortest_path_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item and hold it until it is taken; a random gap may come first.
    task automatic issue_request(input logic [REQ_W-1:0] req, input int idx, input int kind,
                                 input int fk, input int tk, input int al);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_node_index <= NODE_IDX_W'(idx);
        i_node_kind  <= KIND_W'(kind);
        i_from_kind  <= KIND_W'(fk);
        i_to_kind    <= KIND_W'(tk);
        i_allowed    <= al[0];
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    // Let all results drain and the unit settle, then write both registers.
    task automatic set_sizes(input int nodes, input int kinds);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_COUNT;
        i_cfg_data <= CFG_DATA_W'(nodes);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KIND_COUNT;
        i_cfg_data <= CFG_DATA_W'(kinds);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A phase: sizes, the kinds of every node in use if reload is set, some matrix entries,
    // then searches with noise items between them.
    task automatic run_phase(input int nodes, input int kinds, input bit reload,
                             input bit sparse, input int runs);
        int n;
        int kc;
        int krange;
        n      = (nodes == 0) ? 1 : (nodes > DEF_MAX_NODES) ? DEF_MAX_NODES : nodes;
        kc     = (kinds > DEF_MAX_KINDS) ? DEF_MAX_KINDS : kinds;
        krange = (kc == 0) ? 2 : (kc < DEF_MAX_KINDS) ? kc + 1 : kc;
        set_sizes(nodes, kinds);
        if (reload) begin
            for (int i = 1; i <= n; i++) begin
                if (sparse && !(i == 1 || i == n || $urandom_range(0, 200) == 0))
                    issue_request(REQ_LOAD_KIND, i, 0, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 7) == 0)
                    issue_request(REQ_LOAD_KIND, i, $urandom_range(0, 127),
                                  $urandom, $urandom, $urandom);
                else
                    issue_request(REQ_LOAD_KIND, i, $urandom_range(1, krange),
                                  $urandom, $urandom, $urandom);
            end
        end
        repeat ($urandom_range(2, 12))
            issue_request(REQ_LOAD_PERM, $urandom, $urandom,
                          $urandom_range(1, krange), $urandom_range(1, krange),
                          $urandom_range(0, 2) != 0);
        repeat (runs) begin
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 3))
                    0: issue_request(REQ_LOAD_KIND, $urandom_range(0, 2047),
                                     $urandom_range(0, 127), $urandom, $urandom, $urandom);
                    1: issue_request(REQ_LOAD_PERM, $urandom, $urandom,
                                     $urandom_range(0, 127), $urandom_range(0, 127),
                                     $urandom);
                    2: issue_request(REQ_LOAD_PERM, $urandom, $urandom,
                                     $urandom_range(1, krange), $urandom_range(1, krange),
                                     $urandom);
                    default: issue_request(REQ_UNUSED, $urandom, $urandom, $urandom,
                                           $urandom, $urandom);
                endcase
            end
            issue_request(REQ_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int nodes;
        int kinds;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_NODE_COUNT;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_LOAD_KIND;
        i_node_index <= '0;
        i_node_kind  <= '0;
        i_from_kind  <= '0;
        i_to_kind    <= '0;
        i_allowed    <= 1'b0;
        items_sent   = 0;
        quiet        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single node with both counts at zero: node 1 is the target.
        set_sizes(0, 0);
        issue_request(REQ_LOAD_KIND, 1, 1, 0, 0, 0);
        issue_request(REQ_RUN, 0, 0, 0, 0, 0);

        // Two nodes: allowed, forbidden, out-of-range kinds and ignored loads.
        set_sizes(2, 1);
        issue_request(REQ_LOAD_KIND, 1, 1, 0, 0, 0);
        issue_request(REQ_LOAD_KIND, 2, 1, 0, 0, 0);
        issue_request(REQ_RUN, 0, 0, 0, 0, 0);
        issue_request(REQ_LOAD_PERM, 0, 0, 1, 1, 1);
        issue_request(REQ_RUN, 2047, 127, 127, 127, 1);
        issue_request(REQ_LOAD_PERM, 0, 0, 0, 1, 0);
        issue_request(REQ_LOAD_PERM, 0, 0, 1, 127, 0);
        issue_request(REQ_LOAD_PERM, 0, 0, 64, 64, 1);
        issue_request(REQ_LOAD_KIND, 0, 5, 0, 0, 0);
        issue_request(REQ_LOAD_KIND, 2047, 5, 0, 0, 0);
        issue_request(REQ_LOAD_KIND, 1024, 127, 0, 0, 0);
        issue_request(REQ_UNUSED, 2047, 127, 127, 127, 1);
        issue_request(REQ_RUN, 0, 0, 0, 0, 0);
        issue_request(REQ_LOAD_KIND, 2, 127, 0, 0, 0);
        issue_request(REQ_RUN, 0, 0, 0, 0, 0);
        issue_request(REQ_LOAD_KIND, 2, 1, 0, 0, 0);
        issue_request(REQ_LOAD_PERM, 0, 0, 1, 1, 0);
        issue_request(REQ_RUN, 0, 0, 0, 0, 0);

        // Large sizes: counts above the limits are clamped; in the sparse phases few nodes carry a kind.
        run_phase(2047, 127, 1'b1, 1'b1, 2);
        run_phase(1024, 64, 1'b0, 1'b1, 1);
        run_phase(64, 64, 1'b1, 1'b0, 2);
        run_phase(40, 127, 1'b1, 1'b0, 2);

        // Mostly small graphs with random content; the last stretch runs without gaps.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 250) quiet = 1'b1;
            nodes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 20);
            case ($urandom_range(0, 9))
                0:       kinds = 0;
                1:       kinds = 64;
                2:       kinds = 127;
                default: kinds = $urandom_range(1, 6);
            endcase
            run_phase(nodes, kinds, 1'b1, 1'b0, $urandom_range(2, 8));
        end

        // Drain and give the verdict.
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** typed_graph_shortest_path_unit: PASSED **");
        end else begin
            $display("** typed_graph_shortest_path_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tgsp_pkg.sv
hw/rtl/tgsp_perm_store.sv
hw/rtl/typed_graph_shortest_path_unit.sv
tb/tgsp_checker.sv
tb/testbench.sv
